// ===== src/sqrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqrs_pkg: shared types and constants for the rotated sprite quad transform.
// Holds the CORDIC arctangent table, fixed-point constants and the payload
// structs that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sqrs_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ScaleW      = 16;
  localparam int unsigned ExtW        = 34;
  localparam int unsigned SExtW       = 44;
  localparam int unsigned CsW         = 18;
  localparam int unsigned CordW       = 34;

  localparam logic signed [CordW-1:0] CordicKQ30  = 34'sd652032874;
  localparam logic        [31:0]      HalfPiQ30   = 32'd1686629713;
  localparam logic signed [CsW-1:0]   OneQ16      = 18'sd65536;

  localparam logic [4:0] RegHotX  = 5'd0;
  localparam logic [4:0] RegHotY  = 5'd1;
  localparam logic [4:0] RegWidth = 5'd2;
  localparam logic [4:0] RegHeight = 5'd3;

  function automatic logic signed [CordW-1:0] atan_q30(input int unsigned idx);
    logic signed [CordW-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CsW-1:0]    cos_v;
    logic signed [CsW-1:0]    sin_v;
    logic signed [SExtW-1:0]  ex0;
    logic signed [SExtW-1:0]  ex1;
    logic signed [SExtW-1:0]  ey0;
    logic signed [SExtW-1:0]  ey1;
  } sqrs_job_t;

  typedef struct packed {
    logic signed [CoordW-1:0] c0x;
    logic signed [CoordW-1:0] c0y;
    logic signed [CoordW-1:0] c1x;
    logic signed [CoordW-1:0] c1y;
    logic signed [CoordW-1:0] c2x;
    logic signed [CoordW-1:0] c2y;
    logic signed [CoordW-1:0] c3x;
    logic signed [CoordW-1:0] c3y;
    logic signed [CoordW-1:0] mnx;
    logic signed [CoordW-1:0] mny;
    logic signed [CoordW-1:0] mxx;
    logic signed [CoordW-1:0] mxy;
  } sqrs_res_t;

endpackage

// ===== src/sprite_quad_rotate_scale.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_rotate_scale: rotated, scaled sprite quad with bounding box.
//
// Slave stream s_axis carries one sprite placement per item; master stream
// m_axis returns its four corners and bounding box, one item per input.
// Configuration registers (hot spot, sprite size) are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while
// the block is idle, as the block itself does not enforce this. It takes one
// item per cycle while s_axis_tready is high. An item passes the setup stage,
// loaded at the accepting edge, then the CORDIC steps, a rounding stage for
// the sine and cosine, the queue, products, saturating sums and box compare.
// A two-entry queue separates the CORDIC pipeline from the corner
// pipeline. When m_axis_tready is low, the corner pipeline holds, the
// queue fills, and then s_axis_tready drops; no item is lost.
// Reset clears all valid flags and the configuration registers to zero; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module sprite_quad_rotate_scale
  import sqrs_pkg::*;
#(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], angle[79:64], scale_h[95:80], scale_v[111:96]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // corner0_x..corner3_y, box_min_x, box_min_y, box_max_x, box_max_y,
  // 32 bits each from the lowest bit up
  output logic [383:0] m_axis_tdata
);

  logic signed [31:0] hot_x_q, hot_y_q;
  logic [30:0]        width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_x_q  <= '0;
      hot_y_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (5'(cfg_idx_i))
        RegHotX:   hot_x_q  <= cfg_data_i;
        RegHotY:   hot_y_q  <= cfg_data_i;
        RegWidth:  width_q  <= cfg_data_i[30:0];
        RegHeight: height_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic      f_valid, f_ready, b_valid, b_ready;
  sqrs_job_t f_job, b_job;
  sqrs_res_t res;

  sqrs_front #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .pos_x_i    (s_axis_tdata[31:0]),
    .pos_y_i    (s_axis_tdata[63:32]),
    .angle_i    (s_axis_tdata[79:64]),
    .scale_h_i  (s_axis_tdata[95:80]),
    .scale_v_i  (s_axis_tdata[111:96]),
    .hot_x_i    (hot_x_q),
    .hot_y_i    (hot_y_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .job_valid_o(f_valid),
    .job_ready_i(f_ready),
    .job_o      (f_job)
  );

  sqrs_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  sqrs_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {res.mxy, res.mxx, res.mny, res.mnx,
                         res.c3y, res.c3x, res.c2y, res.c2x,
                         res.c1y, res.c1x, res.c0y, res.c0x};

endmodule

// ===== src/sqrs_front.sv =====
// ----------------------------------------------------------------------------
// sqrs_front: pipelined CORDIC and extent scaling.
// Each input item walks one CORDIC step per stage; the scaled extents ride
// alongside. Stages advance together when the downstream queue has room or the output stage is empty.
// ----------------------------------------------------------------------------
module sqrs_front
  import sqrs_pkg::*;
#(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic [15:0]              angle_i,
  input  logic signed [ScaleW-1:0] scale_h_i,
  input  logic signed [ScaleW-1:0] scale_v_i,
  input  logic signed [CoordW-1:0] hot_x_i,
  input  logic signed [CoordW-1:0] hot_y_i,
  input  logic [30:0]              width_i,
  input  logic [30:0]              height_i,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output sqrs_job_t                job_o
);

  localparam int unsigned NS = CORDIC_STEPS;

  logic                    adv;
  logic [NS+1:0]           vld_q;
  logic signed [CordW-1:0] x_q [NS+1];
  logic signed [CordW-1:0] y_q [NS+1];
  logic signed [CordW-1:0] z_q [NS+1];
  logic [1:0]              quad_q [NS+1];
  logic                    exact_q [NS+1];
  sqrs_job_t               pl_q [NS+1];

  logic [23:0]             ang_w;
  logic [31:0]             phase;
  logic [63:0]             zprod;
  logic signed [ExtW-1:0]  e_x0, e_x1, e_y0, e_y1;
  logic signed [ScaleW-1:0] sv;
  logic signed [CordW-1:0] cr, sr;
  logic signed [CsW-1:0]   cc, sc, cf, sf;
  sqrs_job_t               pl0;

  assign adv        = !vld_q[NS+1] || job_ready_i;
  assign in_ready_o = adv;

  function automatic logic signed [SExtW-1:0] scl(input logic signed [ExtW-1:0] e,
                                                  input logic signed [ScaleW-1:0] s);
    logic signed [SExtW+7:0] p;
    p = e * s + (SExtW+8)'(128);
    return SExtW'(p >>> 8);
  endfunction

  function automatic logic signed [CsW-1:0] rnd(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = (v + CordW'(8192)) >>> 14;
    if (r > CordW'(65536)) r = CordW'(65536);
    if (r < -CordW'(65536)) r = -CordW'(65536);
    return CsW'(r);
  endfunction

  always_comb begin
    ang_w = 24'(angle_i);
    phase = 32'(ang_w[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    zprod = {34'd0, phase[29:0]} * {32'd0, HalfPiQ30};
    sv    = (scale_v_i == '0) ? scale_h_i : scale_v_i;
    e_x0  = -ExtW'(hot_x_i);
    e_x1  = ExtW'({1'b0, width_i}) - ExtW'(hot_x_i);
    e_y0  = -ExtW'(hot_y_i);
    e_y1  = ExtW'({1'b0, height_i}) - ExtW'(hot_y_i);
    pl0       = '0;
    pl0.pos_x = pos_x_i;
    pl0.pos_y = pos_y_i;
    pl0.ex0   = scl(e_x0, scale_h_i);
    pl0.ex1   = scl(e_x1, scale_h_i);
    pl0.ey0   = scl(e_y0, sv);
    pl0.ey1   = scl(e_y1, sv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]     <= CordicKQ30;
      y_q[0]     <= '0;
      z_q[0]     <= CordW'(zprod[61:30]);
      quad_q[0]  <= phase[31:30];
      exact_q[0] <= (phase[29:0] == '0);
      pl_q[0]    <= pl0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!z_q[i][CordW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
        quad_q[i+1]  <= quad_q[i];
        exact_q[i+1] <= exact_q[i];
        pl_q[i+1]    <= pl_q[i];
      end
    end
  end

  always_comb begin
    cr = x_q[NS];
    sr = y_q[NS];
    cc = exact_q[NS] ? OneQ16 : rnd(cr);
    sc = exact_q[NS] ? '0 : rnd(sr);
    case (quad_q[NS])
      2'd1:    begin cf = -sc; sf = cc;  end
      2'd2:    begin cf = -cc; sf = -sc; end
      2'd3:    begin cf = sc;  sf = -cc; end
      default: begin cf = cc;  sf = sc;  end
    endcase
  end

  sqrs_job_t job_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      job_q       <= pl_q[NS];
      job_q.cos_v <= cf;
      job_q.sin_v <= sf;
    end
  end

  assign job_valid_o = vld_q[NS+1];
  assign job_o       = job_q;

endmodule

// ===== src/sqrs_fifo.sv =====
// ----------------------------------------------------------------------------
// sqrs_fifo: two-entry queue that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
module sqrs_fifo
  import sqrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  sqrs_job_t wr_data_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output sqrs_job_t rd_data_o
);

  sqrs_job_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== src/sqrs_back.sv =====
// ----------------------------------------------------------------------------
// sqrs_back: corner rotation, saturation and bounding box.
// Stage one forms the products, stage two sums, rounds and saturates, stage
// three takes the box; the last stage is the output register.
// ----------------------------------------------------------------------------
module sqrs_back
  import sqrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  sqrs_job_t job_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output sqrs_res_t res_o
);

  localparam int unsigned PW = SExtW + CsW;
  localparam int unsigned AW = PW + 2;

  logic [2:0] vld_q;
  logic       adv;

  logic signed [PW-1:0]     pxc_q [2], pxs_q [2], pyc_q [2], pys_q [2];
  logic signed [CoordW-1:0] px_q, py_q;
  logic signed [CoordW-1:0] cx_q [4], cy_q [4];
  sqrs_res_t                res_q;

  assign adv         = !vld_q[2] || res_ready_i;
  assign job_ready_o = adv;

  function automatic logic signed [CoordW-1:0] fin(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = (v + AW'(32768)) >>> 16;
    if (r > AW'(64'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (r < -AW'(64'sh80000000)) return 32'sh80000000;
    return CoordW'(r);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[1:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxc_q[0] <= job_i.ex0 * job_i.cos_v;
      pxc_q[1] <= job_i.ex1 * job_i.cos_v;
      pxs_q[0] <= job_i.ex0 * job_i.sin_v;
      pxs_q[1] <= job_i.ex1 * job_i.sin_v;
      pyc_q[0] <= job_i.ey0 * job_i.cos_v;
      pyc_q[1] <= job_i.ey1 * job_i.cos_v;
      pys_q[0] <= job_i.ey0 * job_i.sin_v;
      pys_q[1] <= job_i.ey1 * job_i.sin_v;
      px_q     <= job_i.pos_x;
      py_q     <= job_i.pos_y;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_corner
    localparam int unsigned XI = (k == 1 || k == 2) ? 1 : 0;
    localparam int unsigned YI = (k >= 2) ? 1 : 0;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[k] <= fin(AW'(pxc_q[XI]) - AW'(pys_q[YI]) + (AW'(px_q) <<< 16));
        cy_q[k] <= fin(AW'(pxs_q[XI]) + AW'(pyc_q[YI]) + (AW'(py_q) <<< 16));
      end
    end
  end

  function automatic logic signed [CoordW-1:0] mn2(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    return (b < a) ? b : a;
  endfunction
  function automatic logic signed [CoordW-1:0] mx2(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.c0x <= cx_q[0]; res_q.c0y <= cy_q[0];
      res_q.c1x <= cx_q[1]; res_q.c1y <= cy_q[1];
      res_q.c2x <= cx_q[2]; res_q.c2y <= cy_q[2];
      res_q.c3x <= cx_q[3]; res_q.c3y <= cy_q[3];
      res_q.mnx <= mn2(mn2(cx_q[0], cx_q[1]), mn2(cx_q[2], cx_q[3]));
      res_q.mny <= mn2(mn2(cy_q[0], cy_q[1]), mn2(cy_q[2], cy_q[3]));
      res_q.mxx <= mx2(mx2(cx_q[0], cx_q[1]), mx2(cx_q[2], cx_q[3]));
      res_q.mxy <= mx2(mx2(cy_q[0], cy_q[1]), mx2(cy_q[2], cy_q[3]));
    end
  end

  assign res_valid_o = vld_q[2];
  assign res_o       = res_q;

endmodule

// ===== src/sqrs_checker.sv =====
// ----------------------------------------------------------------------------
// sqrs_checker: port-level checks for the sprite quad transform.
// ----------------------------------------------------------------------------
module sqrs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [383:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_boxx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[287:256]) <= $signed(m_axis_tdata[351:320]))
    else $error("box x inverted");

  a_boxy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[319:288]) <= $signed(m_axis_tdata[383:352]))
    else $error("box y inverted");

  a_c0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[31:0]) >= $signed(m_axis_tdata[287:256]))
    else $error("corner outside box");

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind sprite_quad_rotate_scale sqrs_checker u_sqrs_checker (.*);
